@@ rtl/bdcl_pkg.sv @@
package bdcl_pkg;

  // debounce counter and threshold register width
  localparam int unsigned CntW = 8;
  localparam logic [CntW-1:0] ThreshReset = 8'd5;

  // default button count for the top level
  localparam int unsigned NumButtonsDef = 2;

  // action codes carried in s_axis_tuser
  localparam int unsigned ActW = 2;
  localparam logic [ActW-1:0] ActPoll  = 2'd0;
  localparam logic [ActW-1:0] ActRead  = 2'd1;
  localparam logic [ActW-1:0] ActClear = 2'd2;

  // configuration register index
  localparam logic RegThresh = 1'b0;

  // per-button control, decoded once per accepted transaction
  typedef struct packed {
    logic poll;
    logic clr;
  } btn_ctrl_t;

  // per-button status back to the latch logic
  typedef struct packed {
    logic flip;
    logic live_nxt;
    logic live_cur;
  } btn_stat_t;

endpackage

@@ rtl/bdcl_btn_cell.sv @@
module bdcl_btn_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdcl_pkg::btn_ctrl_t       ctrl_i,
  input  logic                      raw_i,
  input  logic [bdcl_pkg::CntW-1:0] thresh_i,
  output bdcl_pkg::btn_stat_t       stat_o
);
  import bdcl_pkg::*;

  logic            cand_q, cand_d;
  logic            live_q, live_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_inc;
  logic            flip;

  // saturating increment
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CntW'(1);

  always_comb begin
    cand_d = cand_q;
    live_d = live_q;
    cnt_d  = cnt_q;
    flip   = 1'b0;
    if (ctrl_i.clr) begin
      cand_d = 1'b0;
      live_d = 1'b0;
      cnt_d  = '0;
    end else if (ctrl_i.poll) begin
      if (raw_i != cand_q) begin
        cand_d = raw_i;
        cnt_d  = '0;
      end else if (raw_i != live_q) begin
        // a threshold of zero acts as one since cnt_inc is at least one
        if (cnt_inc >= thresh_i) begin
          live_d = raw_i;
          cnt_d  = '0;
          flip   = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= 1'b0;
      live_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      cand_q <= cand_d;
      live_q <= live_d;
      cnt_q  <= cnt_d;
    end
  end

  assign stat_o.flip     = flip;
  assign stat_o.live_nxt = live_d;
  assign stat_o.live_cur = live_q;

endmodule

@@ rtl/bdcl_out_reg.sv @@
module bdcl_out_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [Width-1:0] data_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;

  // space for a new result when empty or when the held one leaves now
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/button_debounce_change_latch_unit.sv @@
// channel   | dir | signals                    | contents
// ----------+-----+----------------------------+---------------------------------------
// s_axis    | in  | tvalid/tready/tdata/tuser  | tuser: action; tdata: raw_buttons
// m_axis    | out | tvalid/tready/tdata        | any_event, change_mask_read, live_state,
//           |     |                            | press_events, irq_pending
// apb       | in  | psel/penable/pwrite/paddr  | debounce_threshold at byte address 0
//
// every button cell and the change latch update in the cycle the input
// transaction is accepted, and the result lands in the output register.
// a new transaction is taken every cycle while the output register is empty or drained.
// the output register stalls input only when it holds a result and m_axis_tready is low.
// reset clears all button state and the latch and loads the threshold with five.
module button_debounce_change_latch_unit #(
  parameter int unsigned NumButtons = bdcl_pkg::NumButtonsDef
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // slave stream
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // raw_buttons from bit 0
  input  logic [((NumButtons+7)/8)*8-1:0]          s_axis_tdata,
  // action
  input  logic [bdcl_pkg::ActW-1:0]                s_axis_tuser,
  // master stream
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // from bit 0: any_event, change_mask_read, live_state, press_events, irq_pending
  output logic [((3*NumButtons+2+7)/8)*8-1:0]      m_axis_tdata,
  // configuration
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [2:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import bdcl_pkg::*;

  localparam int unsigned OutW  = 3 * NumButtons + 2;
  localparam int unsigned OutTW = ((OutW + 7) / 8) * 8;

  // configuration register
  logic [CntW-1:0] thresh_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegThresh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we) begin
      thresh_q <= pwdata[CntW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegThresh) ? 32'(thresh_q) : '0;

  // input transaction decode
  logic                  out_free;
  logic                  in_acc;
  logic [ActW-1:0]       action;
  logic [NumButtons-1:0] raw;
  btn_ctrl_t             ctrl;
  logic                  act_read;

  assign s_axis_tready = out_free;
  assign in_acc        = s_axis_tvalid && out_free;
  assign action        = s_axis_tuser;
  assign raw           = s_axis_tdata[NumButtons-1:0];
  assign ctrl.poll     = in_acc && (action == ActPoll);
  assign ctrl.clr      = in_acc && (action == ActClear);
  assign act_read      = in_acc && (action == ActRead);

  // button cells
  btn_stat_t             stat [NumButtons];
  logic [NumButtons-1:0] flips;
  logic [NumButtons-1:0] live_nxt;
  logic [NumButtons-1:0] live_cur;

  for (genvar b = 0; b < NumButtons; b++) begin : g_btn
    bdcl_btn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .raw_i   (raw[b]),
      .thresh_i(thresh_q),
      .stat_o  (stat[b])
    );
    assign flips[b]    = stat[b].flip;
    assign live_nxt[b] = stat[b].live_nxt;
    assign live_cur[b] = stat[b].live_cur;
  end

  // change, press and interrupt latch
  logic [NumButtons-1:0] changed_q, changed_d;
  logic [NumButtons-1:0] pressed_q, pressed_d;
  logic                  irq_q, irq_d;
  logic                  any_event;

  assign any_event = |flips;

  always_comb begin
    changed_d = changed_q;
    pressed_d = pressed_q;
    irq_d     = irq_q;
    if (ctrl.clr || act_read) begin
      changed_d = '0;
      pressed_d = '0;
      irq_d     = 1'b0;
    end else if (ctrl.poll) begin
      // press latches on rising edges only
      changed_d = changed_q | flips;
      pressed_d = pressed_q | (flips & raw);
      irq_d     = irq_q | any_event;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_q <= '0;
      pressed_q <= '0;
      irq_q     <= 1'b0;
    end else begin
      changed_q <= changed_d;
      pressed_q <= pressed_d;
      irq_q     <= irq_d;
    end
  end

  // result packing
  logic [NumButtons-1:0] mask_read;
  logic [OutW-1:0]       result;

  assign mask_read = act_read ? changed_q : '0;
  assign result    = {irq_d, pressed_d, live_nxt, mask_read, ctrl.poll && any_event};

  bdcl_out_reg #(
    .Width(OutTW)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_acc),
    .data_i (OutTW'(result)),
    .free_o (out_free),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (m_axis_tdata)
  );

  // the interrupt flag mirrors a pending change bit
  a_irq_matches_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q == (|changed_q))
    else $error("irq flag out of step with change mask");

  // a press is always also a change
  a_press_in_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pressed_q & ~changed_q) == '0)
    else $error("press bit without change bit");

  // live levels move only on an accepted poll or clear
  a_live_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.poll || ctrl.clr) |=> $stable(live_cur))
    else $error("live state moved without poll");

  // clear all empties the latch and the live levels
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clr |=> (live_cur == '0) && (changed_q == '0) && !irq_q)
    else $error("clear left state behind");

endmodule
